### sv/lmsc_pkg.sv
// Item types, constants and mode tables for the LED mode step-down controller.
package lmsc_pkg;

  localparam int RAMP_STEPS          = 7;
  localparam int GROUP_COUNT         = 12;
  localparam int LOW_SAMPLES_TO_STEP = 8;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE_GROUP  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_EN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_VOLT_TH = 2'd2;

  localparam logic       OP_POWER_ON   = 1'b0;
  localparam logic       OP_VOLT_SAMPLE = 1'b1;

  localparam logic [4:0] PRESS_MASK      = 5'h1f;
  localparam logic [4:0] PRESS_CFG_LIMIT = 5'd9;
  localparam logic [7:0] LOW_VOLT_TH_RST = 8'd130;

  localparam logic [7:0] CODE_BATT   = 8'd254;
  localparam logic [7:0] CODE_POLICE = 8'd248;
  localparam logic [7:0] CODE_BIKE   = 8'd250;
  localparam logic [7:0] CODE_SOS    = 8'd246;

  typedef struct packed {
    logic       op;
    logic       long_off;
    logic [7:0] voltage;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mode_code;
    logic [7:0] pwm_duty;
    logic       fast_pwm;
    logic       shutdown;
    logic       enter_config;
  } out_item_t;

  // One row of the mode table, entry 0 in the low byte.
  function automatic logic [63:0] group_row(input logic [3:0] row);
    logic [63:0] w;
    case (row)
      4'd0:    w = {CODE_BATT, CODE_BIKE, CODE_POLICE, 8'd7, 8'd5, 8'd3, 8'd2, 8'd1};
      4'd1:    w = {8'd0, 8'd0, 8'd0, 8'd7, 8'd5, 8'd3, 8'd2, 8'd1};
      4'd2:    w = {8'd0, 8'd0, 8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7};
      4'd3:    w = {8'd0, CODE_SOS, CODE_BATT, CODE_BIKE, CODE_POLICE, 8'd7, 8'd4, 8'd2};
      4'd4:    w = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd7, 8'd4, 8'd2};
      4'd5:    w = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd4, 8'd7};
      4'd6:    w = {CODE_SOS, CODE_BATT, CODE_BIKE, CODE_POLICE, 8'd6, 8'd3, 8'd2, 8'd1};
      4'd7:    w = {8'd0, 8'd0, 8'd0, 8'd0, 8'd6, 8'd3, 8'd2, 8'd1};
      4'd8:    w = {8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd2, 8'd3, 8'd6};
      4'd9:    w = {8'd0, 8'd0, 8'd0, 8'd0, 8'd7, 8'd5, 8'd3, 8'd2};
      4'd10:   w = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, CODE_POLICE, 8'd4, 8'd7};
      4'd11:   w = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd7};
      default: w = '0;
    endcase
    return w;
  endfunction

  // Entries before the first zero in a row.
  function automatic logic [3:0] row_count(input logic [63:0] w);
    logic [3:0] n;
    logic       hit_zero;
    n = '0;
    hit_zero = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (w[i*8 +: 8] == 8'd0) begin
        hit_zero = 1'b1;
      end else if (!hit_zero) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] ramp_duty(input logic [3:0] idx);
    logic [7:0] d;
    case (idx)
      4'd0:    d = 8'd1;
      4'd1:    d = 8'd7;
      4'd2:    d = 8'd32;
      4'd3:    d = 8'd63;
      4'd4:    d = 8'd107;
      4'd5:    d = 8'd127;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

endpackage

### sv/led_mode_stepdown_controller_top.sv
// Top level of the LED mode step-down controller: state update and output buffer.
//
// Input channel in_valid / in_stall / in_data carries one item: a power-on
// event (op 0, long_off) or a battery sample (op 1, voltage). Every item
// gives exactly one result on out_valid / out_stall / out_data: mode code,
// PWM duty, fast PWM select, shutdown and enter_config.
// The cfg_ port writes mode_group, memory_enable and low_voltage_threshold
// by index whenever cfg_wr_en is high; write only while no item is pending.
// An accepted item's result is registered in the result register, or in the
// skid register while one waits. One item per cycle is taken while in_stall is
// low; the rate is set by the single state-update stage, mode and ramp lookups.
// A two-entry output buffer (result register plus skid register) keeps
// accepting while one result waits; in_stall rises only once both hold a
// result under out_stall, and a stalled result holds steady.
// Synchronous active-low reset clears mode index, press and low-sample
// counts, level and shutdown, sets the threshold to 130 and empties the
// output buffer.
module led_mode_stepdown_controller_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  lmsc_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output lmsc_pkg::out_item_t                   out_data,
  input  logic                                  cfg_wr_en,
  input  logic [lmsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lmsc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  logic [3:0] mode_group_r;
  logic       memory_en_r;
  logic [7:0] low_volt_th_r;

  logic [2:0] mode_index_r, mode_index_nxt;
  logic [4:0] press_count_r, press_count_nxt;
  logic [7:0] level_r, level_nxt;
  logic [3:0] low_count_r, low_count_nxt;
  logic       powered_down_r, powered_down_nxt;

  lmsc_pkg::out_item_t result;
  lmsc_pkg::out_item_t out_data_r, skid_data_r;
  logic                out_valid_r, skid_valid_r;

  logic        push, pop;
  logic [3:0]  row;
  logic [63:0] row_word;
  logic [3:0]  row_cnt;
  logic [3:0]  next_idx;
  logic [2:0]  idx_sel;
  logic [4:0]  press_inc;
  logic [3:0]  low_inc;
  logic        enter_cfg;

  assign push = in_valid && !in_stall;
  assign pop  = out_valid_r && !out_stall;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    row       = ({1'b0, mode_group_r} < 5'(lmsc_pkg::GROUP_COUNT)) ? mode_group_r : 4'd0;
    row_word  = lmsc_pkg::group_row(row);
    row_cnt   = lmsc_pkg::row_count(row_word);
    next_idx  = {1'b0, mode_index_r} + 4'd1;
    press_inc = (press_count_r + 5'd1) & lmsc_pkg::PRESS_MASK;
    low_inc   = low_count_r + 4'd1;
    idx_sel   = '0;
    enter_cfg = 1'b0;

    mode_index_nxt   = mode_index_r;
    press_count_nxt  = press_count_r;
    level_nxt        = level_r;
    low_count_nxt    = low_count_r;
    powered_down_nxt = powered_down_r;

    if (in_data.op == lmsc_pkg::OP_POWER_ON) begin
      powered_down_nxt = 1'b0;
      low_count_nxt    = '0;
      if (!in_data.long_off) begin
        press_count_nxt = press_inc;
        mode_index_nxt  = (next_idx >= row_cnt) ? 3'd0 : next_idx[2:0];
      end else begin
        press_count_nxt = '0;
        if (!memory_en_r) begin
          mode_index_nxt = '0;
        end
      end
      if (press_count_nxt > lmsc_pkg::PRESS_CFG_LIMIT) begin
        enter_cfg       = 1'b1;
        press_count_nxt = '0;
        mode_index_nxt  = '0;
      end
      idx_sel   = mode_index_nxt;
      level_nxt = ({1'b0, idx_sel} >= row_cnt) ? 8'd0 : row_word[idx_sel*8 +: 8];
    end else if (!powered_down_r) begin
      press_count_nxt = '0;
      low_count_nxt   = (in_data.voltage < low_volt_th_r) ? low_inc : 4'd0;
      if (low_count_nxt >= 4'(lmsc_pkg::LOW_SAMPLES_TO_STEP)) begin
        low_count_nxt = '0;
        if (level_r > 8'(lmsc_pkg::RAMP_STEPS)) begin
          level_nxt = 8'(lmsc_pkg::RAMP_STEPS / 2);
        end else if (level_r > 8'd1) begin
          level_nxt = level_r - 8'd1;
        end else begin
          powered_down_nxt = 1'b1;
        end
      end
    end

    result.mode_code    = level_nxt;
    result.pwm_duty     = '0;
    result.fast_pwm     = 1'b0;
    result.shutdown     = powered_down_nxt;
    result.enter_config = enter_cfg;
    if (!powered_down_nxt && level_nxt >= 8'd1 &&
        level_nxt <= 8'(lmsc_pkg::RAMP_STEPS)) begin
      result.pwm_duty = lmsc_pkg::ramp_duty(4'(level_nxt - 8'd1));
      result.fast_pwm = (level_nxt > 8'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_group_r  <= '0;
      memory_en_r   <= 1'b0;
      low_volt_th_r <= lmsc_pkg::LOW_VOLT_TH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lmsc_pkg::CFG_MODE_GROUP:  mode_group_r  <= cfg_wdata[3:0];
        lmsc_pkg::CFG_MEMORY_EN:   memory_en_r   <= cfg_wdata[0];
        lmsc_pkg::CFG_LOW_VOLT_TH: low_volt_th_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_index_r   <= '0;
      press_count_r  <= '0;
      level_r        <= '0;
      low_count_r    <= '0;
      powered_down_r <= 1'b0;
    end else if (push) begin
      mode_index_r   <= mode_index_nxt;
      press_count_r  <= press_count_nxt;
      level_r        <= level_nxt;
      low_count_r    <= low_count_nxt;
      powered_down_r <= powered_down_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        out_data_r <= result;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_data_r  <= result;
        skid_valid_r <= 1'b1;
      end else begin
        out_data_r  <= result;
        out_valid_r <= 1'b1;
      end
    end
  end

endmodule
